// ===== hdl/ffha_pkg.sv =====
// Shared types and constants of the first-fit heap allocator.
`timescale 1ns / 1ps

package ffha_pkg;

   // Table geometry and heap constants.
   localparam int MAX_CHUNKS = 64;
   localparam int IDX_W      = $clog2(MAX_CHUNKS);
   localparam int LINK_W     = IDX_W + 1;
   localparam int HDR_BYTES  = 16;
   localparam int HEAP_BYTES = 65536;
   localparam int OFS_W      = 16;
   localparam int HSIZE_W    = 17;

   localparam logic [LINK_W-1:0] NIL = LINK_W'(MAX_CHUNKS);

   // Command codes.
   localparam logic [1:0] MODE_ALLOC  = 2'd0;
   localparam logic [1:0] MODE_FREE   = 2'd1;
   localparam logic [1:0] MODE_REINIT = 2'd2;

   // Status codes.
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_ZERO    = 2'd1;
   localparam logic [1:0] ST_NO_FIT  = 2'd2;
   localparam logic [1:0] ST_BAD_FREE = 2'd3;

   // One chunk table entry.
   typedef struct packed {
      logic [OFS_W-1:0]  start;
      logic [OFS_W-1:0]  size;
      logic              used;
      logic [LINK_W-1:0] next;
      logic [LINK_W-1:0] prev;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Command beat.
   typedef struct packed {
      logic [1:0]       mode;
      logic [OFS_W-1:0] request_size;
      logic [OFS_W-1:0] free_address;
   } req_type;

   // Result beat.
   typedef struct packed {
      logic [1:0]       status;
      logic [OFS_W-1:0] address;
   } rsp_type;

   // Control of the spare slot stack.
   typedef struct packed {
      logic             init;
      logic             pop;
      logic             push;
      logic [IDX_W-1:0] slot;
   } spare_ctl_type;

endpackage

// ===== hdl/ffha_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ffha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== hdl/ffha_spare_stack.sv =====
// Stack of spare chunk table slots, held in a RAM with a fill mark.
`timescale 1ns / 1ps

module ffha_spare_stack
   import ffha_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  spare_ctl_type     ctl,
   output logic [IDX_W-1:0]  top,
   output logic [LINK_W-1:0] count
);

   logic [LINK_W-1:0] count_ff;
   logic [LINK_W-1:0] low_ff;
   logic [LINK_W-1:0] top_pos;
   logic [IDX_W-1:0]  rd_data;

   assign top_pos = count_ff - LINK_W'(1);
   assign count   = count_ff;

   // Positions below the low-water mark still hold their rebuild value.
   assign top = (top_pos < low_ff) ? count_ff[IDX_W-1:0] : rd_data;

   ffha_ram #(
      .WIDTH(IDX_W),
      .DEPTH(MAX_CHUNKS)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ctl.push),
      .wr_addr(count_ff[IDX_W-1:0]),
      .wr_data(ctl.slot),
      .rd_addr(top_pos[IDX_W-1:0]),
      .rd_data(rd_data)
   );

   // Fill count and low-water mark.
   always_ff @(posedge clock) begin
      if (reset || ctl.init) begin
         count_ff <= LINK_W'(MAX_CHUNKS - 1);
         low_ff   <= LINK_W'(MAX_CHUNKS - 1);
      end else if (ctl.pop) begin
         count_ff <= top_pos;
         if (top_pos < low_ff) begin
            low_ff <= top_pos;
         end
      end else if (ctl.push) begin
         count_ff <= count_ff + LINK_W'(1);
      end
   end

endmodule

// ===== hdl/first_fit_heap_allocator.sv =====
// Top level of the first-fit heap allocator: command sequencer over the chunk table.
`timescale 1ns / 1ps

// Usage: drive req_item and raise start while busy is low; the command beat
// is taken at that edge and busy rises, but for a zero-size allocate or an
// unused mode, which are answered from idle. Modes are allocate, free and
// reinitialise. Exactly one result beat follows on rsp_item, marked by
// rsp_valid for a single cycle; the receiver cannot hold it off, so it
// must take it then. busy, if it rose, falls in the cycle the result is shown.
// Allocate and free walk the chunk list one table read per cycle, over at
// most 64 chunks; reinitialise rebuilds the single free chunk in S_INIT.
// One command is in flight at a time; the one-read-per-cycle chunk table
// RAM sets the walk rate. heap_size is to be written through csr_wr_en /
// csr_wr_data only while idle (the block does not enforce this) and takes
// effect at the next reinitialise. After reset the block builds the single
// free chunk in S_INIT, with busy high, and gives no result beat for it.
module first_fit_heap_allocator
   import ffha_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_item,
   output logic                 rsp_valid,
   output rsp_type              rsp_item,
   input  logic                 csr_wr_en,
   input  logic [HSIZE_W-1:0]   csr_wr_data
);

   typedef enum logic [3:0] {
      S_IDLE, S_INIT, S_A_WALK, S_A_W1, S_A_W2, S_A_W3,
      S_F_WALK, S_F_RX, S_F_RZ, S_F_RA, S_F_W1, S_F_W2
   } state_type;

   state_type         state_ff;
   logic              pend_ff;
   logic [HSIZE_W-1:0] heap_size_ff;
   req_type           req_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [IDX_W-1:0]  y_ff;
   logic              split_ff;
   entry_type         cur_ff;
   entry_type         xd_ff;
   entry_type         zd_ff;
   entry_type         ad_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   rsp_type           rsp_ff;

   logic              wr_en_in;
   logic [IDX_W-1:0]  wr_addr_in;
   entry_type         wr_entry_in;
   logic [IDX_W-1:0]  rd_addr_in;
   logic [ENTRY_W-1:0] rd_data;
   entry_type         rd;
   spare_ctl_type     spare_ctl;
   logic [IDX_W-1:0]  spare_top;
   logic [LINK_W-1:0] spare_count;

   logic              fit;
   logic              match;
   logic              last;
   logic              split;
   logic [HSIZE_W-1:0] total;
   logic [HSIZE_W-1:0] init_size;
   logic              merge_l;
   logic              merge_r;
   logic [IDX_W-1:0]  keep_idx;
   entry_type         keep_base;
   logic [HSIZE_W-1:0] add_y;
   logic [HSIZE_W-1:0] add_z;
   logic [HSIZE_W-1:0] keep_size;
   logic [LINK_W-1:0] succ_idx;
   entry_type         succ_entry;

   assign rd        = entry_type'(rd_data);
   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // Walk decisions on the entry just read.
   assign fit   = !rd.used && (rd.size >= req_ff.request_size);
   assign match = ({1'b0, rd.start} + HSIZE_W'(HDR_BYTES)) == {1'b0, req_ff.free_address};
   assign last  = (rd.next == NIL);
   assign split = ({1'b0, rd.size} >= ({1'b0, req_ff.request_size} + HSIZE_W'(HDR_BYTES + 1)))
                  && (spare_count != '0);

   // Size of the single chunk built on reset or reinitialise, clamped and saturated.
   assign total     = (heap_size_ff > HSIZE_W'(HEAP_BYTES)) ? HSIZE_W'(HEAP_BYTES)
                                                              : heap_size_ff;
   assign init_size = (total > HSIZE_W'(HDR_BYTES)) ? total - HSIZE_W'(HDR_BYTES) : '0;

   // Merge plan for a free, from the captured neighbours.
   assign merge_l    = (cur_ff.prev != NIL) && !xd_ff.used;
   assign merge_r    = (cur_ff.next != NIL) && !zd_ff.used;
   assign keep_idx   = merge_l ? cur_ff.prev[IDX_W-1:0] : idx_ff;
   assign keep_base  = merge_l ? xd_ff : cur_ff;
   assign add_y      = merge_l ? ({1'b0, cur_ff.size} + HSIZE_W'(HDR_BYTES)) : '0;
   assign add_z      = merge_r ? ({1'b0, zd_ff.size} + HSIZE_W'(HDR_BYTES)) : '0;
   assign keep_size  = {1'b0, keep_base.size} + add_y + add_z;
   assign succ_idx   = merge_r ? zd_ff.next : cur_ff.next;
   assign succ_entry = merge_r ? ad_ff : zd_ff;

   // Table and spare stack accesses for each state.
   always_comb begin
      wr_en_in       = 1'b0;
      wr_addr_in     = '0;
      wr_entry_in    = cur_ff;
      rd_addr_in     = '0;
      spare_ctl      = '0;
      case (state_ff)
         S_INIT: begin
            wr_en_in          = 1'b1;
            wr_entry_in.start = '0;
            wr_entry_in.size  = init_size[OFS_W-1:0];
            wr_entry_in.used  = 1'b0;
            wr_entry_in.next  = NIL;
            wr_entry_in.prev  = NIL;
            spare_ctl.init    = 1'b1;
         end
         S_A_WALK: begin
            rd_addr_in    = rd.next[IDX_W-1:0];
            spare_ctl.pop = fit && split;
         end
         S_A_W1: begin
            wr_en_in         = 1'b1;
            wr_addr_in       = idx_ff;
            wr_entry_in.used = 1'b1;
            if (split_ff) begin
               wr_entry_in.size = req_ff.request_size;
               wr_entry_in.next = {1'b0, y_ff};
            end
         end
         S_A_W2: begin
            wr_en_in          = 1'b1;
            wr_addr_in        = y_ff;
            wr_entry_in.start = cur_ff.start + req_ff.request_size + OFS_W'(HDR_BYTES);
            wr_entry_in.size  = cur_ff.size - req_ff.request_size - OFS_W'(HDR_BYTES);
            wr_entry_in.used  = 1'b0;
            wr_entry_in.next  = cur_ff.next;
            wr_entry_in.prev  = {1'b0, idx_ff};
         end
         S_A_W3: begin
            wr_en_in         = 1'b1;
            wr_addr_in       = cur_ff.next[IDX_W-1:0];
            wr_entry_in      = zd_ff;
            wr_entry_in.prev = {1'b0, y_ff};
         end
         S_F_WALK: begin
            rd_addr_in = (match && rd.used) ? rd.prev[IDX_W-1:0] : rd.next[IDX_W-1:0];
         end
         S_F_RX: begin
            rd_addr_in = cur_ff.next[IDX_W-1:0];
         end
         S_F_RZ: begin
            rd_addr_in = rd.next[IDX_W-1:0];
         end
         S_F_W1: begin
            wr_en_in         = 1'b1;
            wr_addr_in       = keep_idx;
            wr_entry_in      = keep_base;
            wr_entry_in.size = keep_size[OFS_W-1:0];
            wr_entry_in.used = 1'b0;
            wr_entry_in.next = merge_r ? zd_ff.next : cur_ff.next;
            spare_ctl.push   = merge_l || merge_r;
            spare_ctl.slot   = merge_l ? idx_ff : cur_ff.next[IDX_W-1:0];
         end
         S_F_W2: begin
            wr_en_in         = (merge_l || merge_r) && (succ_idx != NIL);
            wr_addr_in       = succ_idx[IDX_W-1:0];
            wr_entry_in      = succ_entry;
            wr_entry_in.prev = {1'b0, keep_idx};
            spare_ctl.push   = merge_l && merge_r;
            spare_ctl.slot   = cur_ff.next[IDX_W-1:0];
         end
         default: begin
            rd_addr_in = '0;
         end
      endcase
   end

   // The result beat is shown in the cycle after each command finishes.
   always_comb begin
      case (state_ff)
         S_IDLE: begin
            rsp_valid_in = start && ((req_item.mode == MODE_ALLOC)
                                     ? (req_item.request_size == '0)
                                     : ((req_item.mode != MODE_FREE) &&
                                        (req_item.mode != MODE_REINIT)));
         end
         S_INIT: begin
            rsp_valid_in = pend_ff;
         end
         S_A_WALK: begin
            rsp_valid_in = !fit && last;
         end
         S_A_W1: begin
            rsp_valid_in = !split_ff;
         end
         S_A_W2: begin
            rsp_valid_in = (cur_ff.next == NIL);
         end
         S_A_W3: begin
            rsp_valid_in = 1'b1;
         end
         S_F_WALK: begin
            rsp_valid_in = !(match && rd.used) && (match || last);
         end
         S_F_W2: begin
            rsp_valid_in = 1'b1;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   ffha_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(MAX_CHUNKS)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en_in),
      .wr_addr(wr_addr_in),
      .wr_data(wr_entry_in),
      .rd_addr(rd_addr_in),
      .rd_data(rd_data)
   );

   ffha_spare_stack u_spare (
      .clock(clock),
      .reset(reset),
      .ctl  (spare_ctl),
      .top  (spare_top),
      .count(spare_count)
   );

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         heap_size_ff <= HSIZE_W'(HEAP_BYTES);
      end else if (csr_wr_en) begin
         heap_size_ff <= csr_wr_data;
      end
   end

   // Command sequencer and result beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  req_ff         <= req_item;
                  idx_ff         <= '0;
                  rsp_ff.status  <= ((req_item.mode == MODE_ALLOC) &&
                                     (req_item.request_size == '0)) ? ST_ZERO : ST_OK;
                  rsp_ff.address <= '0;
                  case (req_item.mode)
                     MODE_ALLOC: begin
                        if (req_item.request_size != '0) begin
                           state_ff <= S_A_WALK;
                        end
                     end
                     MODE_FREE: begin
                        state_ff <= S_F_WALK;
                     end
                     MODE_REINIT: begin
                        pend_ff  <= 1'b1;
                        state_ff <= S_INIT;
                     end
                     default: begin
                        state_ff <= S_IDLE;
                     end
                  endcase
               end
            end
            S_INIT: begin
               pend_ff      <= 1'b0;
               state_ff     <= S_IDLE;
            end
            S_A_WALK: begin
               if (fit) begin
                  cur_ff         <= rd;
                  split_ff       <= split;
                  y_ff           <= spare_top;
                  rsp_ff.address <= rd.start + OFS_W'(HDR_BYTES);
                  state_ff       <= S_A_W1;
               end else if (last) begin
                  rsp_ff.status <= ST_NO_FIT;
                  state_ff      <= S_IDLE;
               end else begin
                  idx_ff <= rd.next[IDX_W-1:0];
               end
            end
            S_A_W1: begin
               zd_ff <= rd;
               if (split_ff) begin
                  state_ff <= S_A_W2;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_A_W2: begin
               if (cur_ff.next != NIL) begin
                  state_ff <= S_A_W3;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_A_W3: begin
               state_ff     <= S_IDLE;
            end
            S_F_WALK: begin
               if (match && rd.used) begin
                  cur_ff   <= rd;
                  state_ff <= S_F_RX;
               end else if (match || last) begin
                  rsp_ff.status <= ST_BAD_FREE;
                  state_ff      <= S_IDLE;
               end else begin
                  idx_ff <= rd.next[IDX_W-1:0];
               end
            end
            S_F_RX: begin
               xd_ff    <= rd;
               state_ff <= S_F_RZ;
            end
            S_F_RZ: begin
               zd_ff    <= rd;
               state_ff <= S_F_RA;
            end
            S_F_RA: begin
               ad_ff    <= rd;
               state_ff <= S_F_W1;
            end
            S_F_W1: begin
               state_ff <= S_F_W2;
            end
            S_F_W2: begin
               state_ff     <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule
